/* hw/rtl/sid_pkg.sv */
package sid_pkg;

  localparam int unsigned ValueW        = 32;
  localparam int unsigned NumDigits     = 10;
  localparam int unsigned DigitW        = 4;
  localparam int unsigned BcdW          = NumDigits * DigitW;
  localparam int unsigned DabbleStages  = 4;
  localparam int unsigned StepsPerStage = ValueW / DabbleStages;
  localparam int unsigned IdxW          = 4;
  localparam int unsigned LenW          = 4;
  localparam int unsigned CharW         = 8;

  localparam logic [CharW-1:0]  CharZero  = 8'h30;
  localparam logic [CharW-1:0]  CharMinus = 8'h2d;
  localparam logic [DigitW-1:0] DabbleMin = 4'd5;
  localparam logic [DigitW-1:0] DabbleAdd = 4'd3;

  // Partial conversion: remaining binary bits and the decimal digits built so far.
  typedef struct packed {
    logic              neg;
    logic [ValueW-1:0] bin;
    logic [BcdW-1:0]   bcd;
  } conv_t;

  // Finished conversion, ready for the character serializer.
  typedef struct packed {
    logic            neg;
    logic [BcdW-1:0] bcd;
    logic [IdxW-1:0] top_idx;
    logic [LenW-1:0] total;
  } text_t;

  // One shift-and-add-3 step: correct every digit, then shift one binary bit in.
  function automatic conv_t dabble_step(conv_t s);
    conv_t           r;
    logic [BcdW-1:0] adj;
    adj = s.bcd;
    for (int d = 0; d < NumDigits; d++) begin
      if (adj[d*DigitW +: DigitW] >= DabbleMin) begin
        adj[d*DigitW +: DigitW] = adj[d*DigitW +: DigitW] + DabbleAdd;
      end
    end
    r.neg = s.neg;
    r.bcd = {adj[BcdW-2:0], s.bin[ValueW-1]};
    r.bin = {s.bin[ValueW-2:0], 1'b0};
    return r;
  endfunction

  // The share of the conversion done by one pipeline stage.
  function automatic conv_t dabble_stage(conv_t s);
    conv_t r;
    r = s;
    for (int i = 0; i < StepsPerStage; i++) begin
      r = dabble_step(r);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/sid_if.sv */
interface sid_in_if import sid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sid_out_if import sid_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             is_last;
  logic [LenW-1:0]  total_length;

  modport source (output valid, output char_code, output is_last, output total_length,
                  input ready);
  modport sink (input valid, input char_code, input is_last, input total_length,
                output ready);
endinterface

/* hw/rtl/signed_int_to_decimal_ascii.sv */
// Converts each 32-bit two's-complement word on in_i into its decimal ASCII text and sends
// it on out_o one character per word, most significant character first, with a leading
// minus sign for negative values and a single '0' for zero. Every character word carries
// is_last on the final character and the total text length (1 to 11). A value first passes
// a six-stage pipeline (input register, four binary-to-decimal stages of eight
// shift-and-add-3 steps each, and a digit count stage) before its first character appears.
// The character serializer at the end emits one character per cycle while out_o is ready,
// so each value occupies the output for one character word per character of its text;
// that serializer sets the sustained rate. Up to six further values are accepted and held
// in the pipeline while a text is still being sent, and a stall on out_o holds everything
// in place without loss. No state is kept from one value to the next.
module signed_int_to_decimal_ascii import sid_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sid_in_if.sink    in_i,
  sid_out_if.source out_o
);

  // Conversion pipeline: stage 0 is the input register, stages 1..DabbleStages convert.
  logic [DabbleStages:0] conv_vld_q;
  logic [DabbleStages:0] conv_rdy;
  conv_t                 conv_q [DabbleStages+1];

  logic              in_neg;
  logic [ValueW-1:0] in_raw;
  logic [ValueW-1:0] in_mag;

  // Digit count stage.
  logic            text_vld_q;
  logic            text_rdy;
  text_t           text_q;
  text_t           text_d;
  logic [IdxW-1:0] top_idx_d;

  // Character serializer.
  logic            ser_busy_q;
  logic            ser_sign_q;
  logic [IdxW-1:0] ser_idx_q;
  logic [BcdW-1:0] ser_bcd_q;
  logic [LenW-1:0] ser_total_q;
  logic            ser_free;
  logic            ser_load;
  logic            out_take;

  // The two's-complement negate of the most negative value is its own magnitude when
  // read as unsigned, so 32 magnitude bits cover the whole range.
  assign in_raw = unsigned'(in_i.value);
  assign in_neg = in_raw[ValueW-1];
  assign in_mag = in_neg ? (~in_raw + ValueW'(1)) : in_raw;

  assign in_i.ready = conv_rdy[0];

  // A stage can take a new word when it is empty or when its word moves on this cycle.
  always_comb begin
    for (int k = 0; k < DabbleStages; k++) begin
      conv_rdy[k] = !conv_vld_q[k] || conv_rdy[k+1];
    end
    conv_rdy[DabbleStages] = !conv_vld_q[DabbleStages] || text_rdy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_vld_q <= '0;
    end else begin
      if (conv_rdy[0]) begin
        conv_vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k <= DabbleStages; k++) begin
        if (conv_rdy[k]) begin
          conv_vld_q[k] <= conv_vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && conv_rdy[0]) begin
      conv_q[0] <= '{neg: in_neg, bin: in_mag, bcd: '0};
    end
    for (int k = 1; k <= DabbleStages; k++) begin
      if (conv_vld_q[k-1] && conv_rdy[k]) begin
        conv_q[k] <= dabble_stage(conv_q[k-1]);
      end
    end
  end

  // The text starts at the highest nonzero digit; a value of zero still shows one digit.
  always_comb begin
    top_idx_d = '0;
    for (int d = 1; d < NumDigits; d++) begin
      if (conv_q[DabbleStages].bcd[d*DigitW +: DigitW] != '0) begin
        top_idx_d = IdxW'(d);
      end
    end
    text_d.neg     = conv_q[DabbleStages].neg;
    text_d.bcd     = conv_q[DabbleStages].bcd;
    text_d.top_idx = top_idx_d;
    text_d.total   = LenW'(top_idx_d) + LenW'(1) + LenW'(conv_q[DabbleStages].neg);
  end

  assign text_rdy = !text_vld_q || ser_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_vld_q <= 1'b0;
    end else if (text_rdy) begin
      text_vld_q <= conv_vld_q[DabbleStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (conv_vld_q[DabbleStages] && text_rdy) begin
      text_q <= text_d;
    end
  end

  // The serializer sends the sign first, if any, then the digits from the top index down.
  assign out_o.valid        = ser_busy_q;
  assign out_o.char_code    = ser_sign_q ? CharMinus
                                         : CharZero + CharW'(ser_bcd_q[ser_idx_q*DigitW +: DigitW]);
  assign out_o.is_last      = !ser_sign_q && (ser_idx_q == '0);
  assign out_o.total_length = ser_total_q;

  assign out_take = out_o.valid && out_o.ready;
  assign ser_free = !ser_busy_q || (out_take && out_o.is_last);
  assign ser_load = text_vld_q && ser_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_busy_q <= 1'b0;
      ser_sign_q <= 1'b0;
      ser_idx_q  <= '0;
    end else if (ser_load) begin
      ser_busy_q <= 1'b1;
      ser_sign_q <= text_q.neg;
      ser_idx_q  <= text_q.top_idx;
    end else if (ser_free) begin
      ser_busy_q <= 1'b0;
    end else if (out_take) begin
      if (ser_sign_q) begin
        ser_sign_q <= 1'b0;
      end else begin
        ser_idx_q <= ser_idx_q - IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_bcd_q   <= text_q.bcd;
      ser_total_q <= text_q.total;
    end
  end

  // The digit index never leaves the stored digits while a character is shown.
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_busy_q |-> (ser_idx_q < IdxW'(NumDigits)))
    else $error("digit index out of range");

  // A text that is not finished keeps going on the next cycle.
  a_text_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !out_o.is_last) |=> out_o.valid)
    else $error("text ended before its last character");

  // The length stays the same across the characters of one text.
  a_length_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_take && !out_o.is_last) |=> $stable(out_o.total_length))
    else $error("total length changed within a text");

  // The reported length is always between one and eleven characters.
  a_length_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.total_length >= LenW'(1)) && (out_o.total_length <= LenW'(11))))
    else $error("total length out of range");

  // A converted word that cannot move on is still held in the next cycle.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (conv_vld_q[DabbleStages] && !conv_rdy[DabbleStages]) |=> conv_vld_q[DabbleStages])
    else $error("stalled word dropped from the last conversion stage");

endmodule
